@@ rtl/b64le_pkg.sv @@
// Package for the Base64 line encoder: character constants and the
// standard alphabet lookup. No dependencies.
package b64le_pkg;

    localparam logic [7:0] CHAR_PAD = 8'h3D;  // '='
    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_LF  = 8'h0A;

    localparam logic [7:0] LINE_WIDTH_RESET = 8'd76;

    // Number of characters a single input byte can produce.
    localparam int unsigned MAX_CHARS = 6;

    typedef logic [7:0] char_t;
    typedef char_t      char_batch_t [MAX_CHARS];

    // Maps a 6-bit sextet to its character in the standard alphabet.
    function automatic char_t b64_char(input logic [5:0] sextet);
        char_t ch;
        if (sextet < 6'd26) begin
            ch = 8'd65 + {2'b00, sextet};          // 'A'..'Z'
        end else if (sextet < 6'd52) begin
            ch = 8'd71 + {2'b00, sextet};          // 'a'..'z'
        end else if (sextet < 6'd62) begin
            ch = {2'b00, sextet} - 8'd4;           // '0'..'9'
        end else if (sextet == 6'd62) begin
            ch = 8'h2B;                            // '+'
        end else begin
            ch = 8'h2F;                            // '/'
        end
        return ch;
    endfunction

endpackage

@@ rtl/base64_line_encoder_top.sv @@
// Streaming Base64 encoder with CR LF line wrapping after full groups.
// Depends on b64le_pkg for the alphabet and character constants.
//
// A byte beat is accepted in any cycle in which the staging register is free,
// so bytes may arrive back to back. Each accepted byte is encoded in the same
// cycle into a batch of zero, four or six characters (four per group, plus
// CR LF when the line fills; a final partial group gives four with '='
// padding). Characters leave one per cycle on the m_ side while m_tready is
// high, so the sustained rate is set by that port: four to six characters
// per three bytes. One batch can wait in the staging register while the
// previous one is still being sent. line_width is written through the cfg_
// channel, which is always ready.
module base64_line_encoder_top
    import b64le_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data,     // line_width

    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,      // [7:0] data_byte
    input  logic       s_tlast,      // final_byte

    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,      // [7:0] out_char
    output logic       m_tlast       // last_char
);

    logic [7:0]  line_width_reg;
    logic [15:0] pend_bytes_reg, pend_bytes_next;
    logic [1:0]  pend_cnt_reg, pend_cnt_next;
    logic [7:0]  line_cnt_reg, line_cnt_next;

    char_batch_t gen_chars;
    logic [2:0]  gen_cnt;

    char_batch_t batch_chars_reg;
    logic [2:0]  batch_cnt_reg;
    logic        batch_fin_reg;
    logic        batch_valid_reg;

    char_batch_t out_chars_reg;
    logic [2:0]  out_cnt_reg;
    logic [2:0]  out_idx_reg;
    logic        out_fin_reg;
    logic        out_valid_reg;

    logic        s_fire, m_fire, out_last_beat, out_free, batch_take;
    logic [23:0] group;
    logic [17:0] pair;
    logic [8:0]  line_sum;
    logic        line_break;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg <= LINE_WIDTH_RESET;
        end else if (cfg_valid && cfg_ready) begin
            line_width_reg <= cfg_data;
        end
    end

    // Encode the incoming byte against the pending bytes.
    always_comb begin
        group      = {pend_bytes_reg, s_tdata};
        pair       = {pend_bytes_reg[7:0], s_tdata, 2'b00};
        line_sum   = {1'b0, line_cnt_reg} + 9'd4;
        line_break = line_sum >= {1'b0, line_width_reg};

        for (int i = 0; i < MAX_CHARS; i++) begin
            gen_chars[i] = CHAR_PAD;
        end
        gen_cnt         = 3'd0;
        pend_bytes_next = pend_bytes_reg;
        pend_cnt_next   = pend_cnt_reg;
        line_cnt_next   = line_cnt_reg;

        if (pend_cnt_reg[1]) begin
            gen_chars[0] = b64_char(group[23:18]);
            gen_chars[1] = b64_char(group[17:12]);
            gen_chars[2] = b64_char(group[11:6]);
            gen_chars[3] = b64_char(group[5:0]);
            gen_chars[4] = CHAR_CR;
            gen_chars[5] = CHAR_LF;
            if (line_break) begin
                gen_cnt       = 3'd6;
                line_cnt_next = 8'd0;
            end else begin
                gen_cnt       = 3'd4;
                line_cnt_next = line_sum[7:0];
            end
            pend_bytes_next = 16'd0;
            pend_cnt_next   = 2'd0;
        end else if (s_tlast && pend_cnt_reg == 2'd0) begin
            gen_chars[0] = b64_char(s_tdata[7:2]);
            gen_chars[1] = b64_char({s_tdata[1:0], 4'b0000});
            gen_cnt      = 3'd4;
        end else if (s_tlast) begin
            gen_chars[0] = b64_char(pair[17:12]);
            gen_chars[1] = b64_char(pair[11:6]);
            gen_chars[2] = b64_char(pair[5:0]);
            gen_cnt      = 3'd4;
        end else begin
            pend_bytes_next = {pend_bytes_reg[7:0], s_tdata};
            pend_cnt_next   = pend_cnt_reg + 2'd1;
        end

        // The end of a message returns the encoder to its starting state.
        if (s_tlast) begin
            pend_bytes_next = 16'd0;
            pend_cnt_next   = 2'd0;
            line_cnt_next   = 8'd0;
        end
    end

    assign out_last_beat = out_idx_reg == (out_cnt_reg - 3'd1);
    assign m_fire        = out_valid_reg && m_tready;
    assign out_free      = !out_valid_reg || (m_tready && out_last_beat);
    assign batch_take    = batch_valid_reg && out_free;
    assign s_tready      = !batch_valid_reg || batch_take;
    assign s_fire        = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_bytes_reg <= 16'd0;
            pend_cnt_reg   <= 2'd0;
            line_cnt_reg   <= 8'd0;
        end else if (s_fire) begin
            pend_bytes_reg <= pend_bytes_next;
            pend_cnt_reg   <= pend_cnt_next;
            line_cnt_reg   <= line_cnt_next;
        end
    end

    // Staging register: holds one encoded batch until the output side is free.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            batch_valid_reg <= 1'b0;
        end else if (s_fire && gen_cnt != 3'd0) begin
            batch_valid_reg <= 1'b1;
        end else if (batch_take) begin
            batch_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && gen_cnt != 3'd0) begin
            batch_chars_reg <= gen_chars;
            batch_cnt_reg   <= gen_cnt;
            batch_fin_reg   <= s_tlast;
        end
    end

    // Output buffer: sends its characters one beat at a time.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            out_idx_reg   <= 3'd0;
        end else if (out_free) begin
            out_valid_reg <= batch_valid_reg;
            out_idx_reg   <= 3'd0;
        end else if (m_fire) begin
            out_idx_reg <= out_idx_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (batch_take) begin
            out_chars_reg <= batch_chars_reg;
            out_cnt_reg   <= batch_cnt_reg;
            out_fin_reg   <= batch_fin_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_chars_reg[out_idx_reg];
    assign m_tlast  = out_fin_reg && out_last_beat;

`ifndef SYNTHESIS
    a_out_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_cnt_reg != 3'd0 && out_idx_reg < out_cnt_reg))
        else $error("output index beyond the loaded batch");

    a_pend_cnt_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_cnt_reg != 2'd3)
        else $error("pending count reached three");

    a_line_cnt_groups: assert property (@(posedge aclk) disable iff (!aresetn)
        line_cnt_reg[1:0] == 2'b00)
        else $error("line count is not a whole number of groups");

    a_final_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_tlast) |=> (pend_cnt_reg == 2'd0 && line_cnt_reg == 8'd0))
        else $error("state not cleared after the final byte");

    a_batch_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (batch_valid_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("staged batch did not move to the output buffer");
`endif

endmodule
